// ===== hdl/ttw_pkg.sv =====
// ----------------------------------------------------------------------------
// Translation table walker package
// Shared codes, controller states and the command and status bundles that
// join the walk controller to its datapath.
// ----------------------------------------------------------------------------
package ttw_pkg;

    // Address widths.
    localparam int PA_W   = 48;
    localparam int PHYS_W = 49;

    // Item opcodes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FAULT  = 2'd1;
    localparam logic [1:0] STAT_WINDOW = 2'd2;

    // Mapping size codes.
    localparam logic [1:0] SIZE_1G = 2'd0;
    localparam logic [1:0] SIZE_2M = 2'd1;
    localparam logic [1:0] SIZE_4K = 2'd2;

    // Descriptor type field, bits 1:0.
    localparam logic [1:0] KIND_BLOCK = 2'b01;
    localparam logic [1:0] KIND_TABLE = 2'b11;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ROOT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ROOT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PRESENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } ttw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clear;     // write zero to the next word of the clearing pass
        logic       store;     // store the descriptor of an accepted write word
        logic       start;     // accepted lookup: latch address, issue root read
        logic       step;      // descend one level: issue the next table read
        logic       load_out;  // capture the walk result in the output register
        logic [1:0] level;     // level of the entry now in the read register
    } ttw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its last word
        logic walk_done;   // the current walk has its result
    } ttw_stat_t;

endpackage

// ===== hdl/translation_table_walker.sv =====
// ----------------------------------------------------------------------------
// Translation table walker
// Four-level walk over 4 KB-granule translation tables held in a local
// table memory window, with descriptor writes and a register write port.
// ----------------------------------------------------------------------------
// Walk length: a lookup that reaches level 3 takes longest; a block at level
// 1 or 2 or a fault at an earlier level ends the walk sooner.
// Throughput: one descriptor write per cycle when idle; no new word is taken
// until a lookup's dependent reads through the read port load its result.
// Reset: a clearing pass zeroes all min(WIN_PAGES * 512, 8192) words of the
// table memory; s_ready stays low meanwhile, register writes are taken.
// ----------------------------------------------------------------------------
module translation_table_walker
    import ttw_pkg::*;
#(
    parameter int WIN_PAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PA_W-1:0]      cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [63:0]          s_virtual_addr,
    input  logic [12:0]          s_word_index,
    input  logic [63:0]          s_descriptor,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PHYS_W-1:0]    m_phys_addr,
    output logic [1:0]           m_map_size,
    output logic [1:0]           m_status
);

    ttw_cmd_t  ctrl_cmd;
    ttw_stat_t dp_stat;

    // The port never pushes back. The user must write the registers only while
    // no lookup is in flight; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    // The controller owns the handshakes, the walk level and the output
    // valid flag. It accepts a word only in its idle state: a write word is
    // stored in that same cycle, a lookup word issues its root table read in
    // that cycle and then descends one level per cycle. A finished walk
    // waits in place when the previous result has not yet been taken.
    ttw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // The datapath holds the registers, the table memory, the entry address
    // and window check feeding the memory read address, the descriptor
    // decode on the registered read data, and the result register.
    ttw_datapath #(
        .WIN_PAGES (WIN_PAGES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_virtual_addr (s_virtual_addr),
        .s_word_index   (s_word_index),
        .s_descriptor   (s_descriptor),
        .cmd            (ctrl_cmd),
        .stat           (dp_stat),
        .m_phys_addr    (m_phys_addr),
        .m_map_size     (m_map_size),
        .m_status       (m_status)
    );

    // A result is loaded only into a free or draining output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |-> (!m_valid || m_ready))
        else $error("walk result loaded over an untaken result");

    // A loaded result is presented and the block returns to accepting words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |=> (m_valid && s_ready))
        else $error("loaded result not presented or block not idle");

    // No word is taken while a lookup walks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_LOOKUP) |=> !s_ready)
        else $error("word accepted during a walk");

    // The clearing pass never overlaps item acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.clear |-> (!s_ready && !m_valid))
        else $error("item traffic during the clearing pass");

endmodule

// ===== hdl/ttw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ttw_datapath.sv =====
// ----------------------------------------------------------------------------
// Translation table walker datapath
// Configuration registers, table memory, entry address and window check,
// descriptor decode and the result register.
// ----------------------------------------------------------------------------
module ttw_datapath
    import ttw_pkg::*;
#(
    parameter int WIN_PAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PA_W-1:0]      cfg_data,
    input  logic [63:0]          s_virtual_addr,
    input  logic [12:0]          s_word_index,
    input  logic [63:0]          s_descriptor,
    input  ttw_cmd_t             cmd,
    output ttw_stat_t            stat,
    output logic [PHYS_W-1:0]    m_phys_addr,
    output logic [1:0]           m_map_size,
    output logic [1:0]           m_status
);

    localparam int WORDS     = WIN_PAGES * 512;
    localparam int WIN_BYTES = WIN_PAGES * 4096;
    // Only the first 8192 words can be written; the rest of a larger window
    // always reads as zero and needs no storage.
    localparam int MEM_DEPTH = (WORDS > 8192) ? 8192 : WORDS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic [PA_W-1:0]   low_root_reg;
    logic [PA_W-1:0]   high_root_reg;
    logic              low_present_reg;
    logic              high_present_reg;
    logic [PA_W-1:0]   win_base_reg;

    logic [PA_W-1:0]   va_reg;
    logic [1:0]        early_reg;
    logic [1:0]        early_next;
    logic              zero_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    logic [PHYS_W-1:0] phys_reg;
    logic [1:0]        size_reg;
    logic [1:0]        status_reg;

    logic [63:0]       rdata;
    logic [63:0]       entry;
    logic [1:0]        kind;

    logic [35:0]       tbl;
    logic [8:0]        idx;
    logic              present;
    logic [PA_W-1:0]   entry_addr;
    logic [PA_W:0]     diff;
    logic              outside;
    logic [WORD_AW-1:0] word;
    logic              beyond_mem;
    logic              issue;
    logic              re;

    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [63:0]       wdata;

    logic              res_done;
    logic [1:0]        res_status;
    logic [1:0]        res_size;
    logic [PHYS_W-1:0] res_phys;
    logic [PHYS_W-1:0] blk_base;
    logic [PHYS_W-1:0] blk_off;

    function automatic logic [8:0] level_index(input logic [PA_W-1:0] va,
                                               input logic [1:0] lvl);
        logic [8:0] r;
        case (lvl)
            2'd0:    r = va[47:39];
            2'd1:    r = va[38:30];
            2'd2:    r = va[29:21];
            default: r = va[20:12];
        endcase
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_root_reg     <= '0;
            high_root_reg    <= '0;
            low_present_reg  <= 1'b0;
            high_present_reg <= 1'b0;
            win_base_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOW_ROOT:     low_root_reg     <= cfg_data;
                CFG_HIGH_ROOT:    high_root_reg    <= cfg_data;
                CFG_LOW_PRESENT:  low_present_reg  <= cfg_data[0];
                CFG_HIGH_PRESENT: high_present_reg <= cfg_data[0];
                CFG_WINDOW_BASE:  win_base_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry address of the next table read, from the root or from the
    // table descriptor that was just read.
    always_comb begin
        if (cmd.start) begin
            tbl     = s_virtual_addr[63] ? high_root_reg[47:12] : low_root_reg[47:12];
            present = s_virtual_addr[63] ? high_present_reg : low_present_reg;
            idx     = s_virtual_addr[47:39];
        end else begin
            tbl     = entry[47:12];
            present = 1'b1;
            idx     = level_index(va_reg, cmd.level + 2'd1);
        end
        entry_addr = {tbl, idx, 3'b000};
        diff       = {1'b0, entry_addr} - {1'b0, win_base_reg};
        outside    = diff[PA_W] || (diff[PA_W-1:0] >= PA_W'(WIN_BYTES));
        word       = diff[3 +: WORD_AW];
        beyond_mem = ({1'b0, word} >= (WORD_AW + 1)'(MEM_DEPTH));
        issue      = cmd.start || cmd.step;
        re         = issue && present && !outside && !beyond_mem;
        if (!present) begin
            early_next = STAT_FAULT;
        end else if (outside) begin
            early_next = STAT_WINDOW;
        end else begin
            early_next = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            va_reg <= s_virtual_addr[PA_W-1:0];
        end
        if (issue) begin
            early_reg <= early_next;
            zero_reg  <= beyond_mem;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
        end
    end

    assign stat.clear_last = (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1));

    always_comb begin
        we    = cmd.clear || (cmd.store && ({1'b0, s_word_index} < 14'(MEM_DEPTH)));
        waddr = cmd.clear ? clr_cnt_reg : s_word_index[MEM_AW-1:0];
        wdata = cmd.clear ? 64'd0 : s_descriptor;
    end

    ttw_ram #(
        .WIDTH (64),
        .DEPTH (MEM_DEPTH)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (word[MEM_AW-1:0]),
        .rdata (rdata)
    );

    assign entry = zero_reg ? 64'd0 : rdata;
    assign kind  = entry[1:0];

    // Descriptor decode for the level held in cmd.level.
    always_comb begin
        blk_base   = {1'b0, entry[47:12], 12'b0};
        case (cmd.level)
            2'd1:    blk_off = {19'b0, va_reg[29:0]};
            2'd2:    blk_off = {28'b0, va_reg[20:0]};
            default: blk_off = {37'b0, va_reg[11:0]};
        endcase
        res_done   = 1'b1;
        res_status = STAT_FAULT;
        res_size   = SIZE_1G;
        res_phys   = '0;
        if (early_reg != STAT_OK) begin
            res_status = early_reg;
        end else begin
            case (cmd.level)
                2'd3: begin
                    if (kind == KIND_TABLE) begin
                        res_status = STAT_OK;
                        res_size   = SIZE_4K;
                        res_phys   = blk_base + blk_off;
                    end
                end
                2'd1, 2'd2: begin
                    if (kind == KIND_BLOCK) begin
                        res_status = STAT_OK;
                        res_size   = (cmd.level == 2'd1) ? SIZE_1G : SIZE_2M;
                        res_phys   = blk_base + blk_off;
                    end else if (kind == KIND_TABLE) begin
                        res_done = 1'b0;
                    end
                end
                default: begin
                    if (kind == KIND_TABLE) begin
                        res_done = 1'b0;
                    end
                end
            endcase
        end
    end

    assign stat.walk_done = res_done;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            phys_reg   <= res_phys;
            size_reg   <= res_size;
            status_reg <= res_status;
        end
    end

    assign m_phys_addr = phys_reg;
    assign m_map_size  = size_reg;
    assign m_status    = status_reg;

endmodule

// ===== hdl/ttw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Translation table walker controller
// Sequences the clearing pass, item acceptance, the level walk and the
// output register handshake.
// ----------------------------------------------------------------------------
module ttw_ctrl
    import ttw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_opcode,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ttw_stat_t stat,
    output ttw_cmd_t  cmd
);

    ttw_state_t state_reg;
    ttw_state_t state_next;
    logic [1:0] lvl_reg;
    logic [1:0] lvl_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            lvl_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.level  = lvl_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OP_LOOKUP) begin
                        cmd.start  = 1'b1;
                        lvl_next   = 2'd0;
                        state_next = S_WALK;
                    end else begin
                        cmd.store = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    // Hold the finished walk until the output register frees.
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                    lvl_next = lvl_reg + 2'd1;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
        m_valid_next = cmd.load_out || (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== tb/tb_translation_table_walker.sv =====
// ----------------------------------------------------------------------------
// Translation table walker testbench
// Builds four-level translation tables through descriptor writes, looks up
// addresses through them, and compares every result against a walk computed
// in the bench from its own copy of the table memory and the registers.
// ----------------------------------------------------------------------------
module tb_translation_table_walker;
    import ttw_pkg::*;

    localparam int WIN_PAGES    = 16;
    localparam int WINDOW_WORDS = WIN_PAGES * 512;
    localparam logic [63:0] WINDOW_BYTES = 64'(WIN_PAGES) * 64'h1000;

    // Output-address field of a descriptor and the offset within a 4 KB page.
    localparam logic [63:0] OA_MASK     = 64'h0000_FFFF_FFFF_F000;
    localparam logic [63:0] PAGE_OFFSET = 64'h0000_0000_0000_0FFF;

    // A register index that names no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // A walk is at most four dependent reads plus the output stage, so this is
    // more than enough for a trailing descriptor write to land.
    localparam int WALK_SETTLE = 12;

    // A bound well above the clearing pass and the slowest legal run together.
    localparam int unsigned CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [PHYS_W-1:0] phys;
        logic [1:0]        size;
        logic [1:0]        status;
    } walk_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a private copy of the table memory and the registers,
    // works out the walk for every accepted lookup, and checks the results in
    // order.
    // ------------------------------------------------------------------------
    class translation_checker;
        logic [63:0]     desc_mem [WINDOW_WORDS];
        logic [PA_W-1:0] low_root;
        logic [PA_W-1:0] high_root;
        logic            low_present;
        logic            high_present;
        logic [PA_W-1:0] win_base;
        walk_result_t    pending_walks [$];
        int              errors;

        function new();
            foreach (desc_mem[i]) desc_mem[i] = '0;
            low_root     = '0;
            high_root    = '0;
            low_present  = 1'b0;
            high_present = 1'b0;
            win_base     = '0;
            errors       = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [PA_W-1:0] data);
            case (idx)
                CFG_LOW_ROOT:     low_root     = data;
                CFG_HIGH_ROOT:    high_root    = data;
                CFG_LOW_PRESENT:  low_present  = data[0];
                CFG_HIGH_PRESENT: high_present = data[0];
                CFG_WINDOW_BASE:  win_base     = data;
                default: ;
            endcase
        endfunction

        // Word slot of a table entry address; returns 0 when the entry lies
        // outside the window. The low three bits of the offset are dropped.
        function bit entry_slot(logic [63:0] addr, output logic [12:0] slot);
            logic [63:0] off;
            off  = addr - {16'b0, win_base};
            slot = 13'(off >> 3);
            return (addr >= {16'b0, win_base}) && (off < WINDOW_BYTES);
        endfunction

        function walk_result_t walk_va(logic [63:0] va);
            walk_result_t r;
            logic [63:0]  tbl;
            logic [63:0]  entry;
            logic [63:0]  span;
            logic [12:0]  slot;
            int           lvl;
            int           shift;
            r        = '0;
            r.status = STAT_FAULT;
            if (!(va[63] ? high_present : low_present))
                return r;
            tbl = {16'b0, (va[63] ? high_root : low_root)} & OA_MASK;
            for (lvl = 0; lvl < 4; lvl++) begin
                shift = 39 - 9 * lvl;
                if (!entry_slot(tbl + (((va >> shift) & 64'h1FF) << 3), slot)) begin
                    r.status = STAT_WINDOW;
                    return r;
                end
                entry = desc_mem[slot];
                if (lvl == 3) begin
                    // Only a page descriptor gives a mapping at the last level.
                    if (entry[1:0] == KIND_TABLE) begin
                        r.phys   = PHYS_W'((entry & OA_MASK) + (va & PAGE_OFFSET));
                        r.size   = SIZE_4K;
                        r.status = STAT_OK;
                    end
                    return r;
                end
                if (entry[1:0] == KIND_BLOCK && lvl != 0) begin
                    span     = (64'd1 << shift) - 64'd1;
                    r.phys   = PHYS_W'((entry & OA_MASK) + (va & span));
                    r.size   = (lvl == 1) ? SIZE_1G : SIZE_2M;
                    r.status = STAT_OK;
                    return r;
                end
                if (entry[1:0] != KIND_TABLE)
                    return r;
                tbl = entry & OA_MASK;
            end
            return r;
        endfunction

        function void note_word(logic op, logic [63:0] va, logic [12:0] slot,
                                logic [63:0] desc);
            if (op == OP_WRITE) begin
                if (slot < WINDOW_WORDS)
                    desc_mem[slot] = desc;
            end else begin
                pending_walks.push_back(walk_va(va));
            end
        endfunction

        function void check_result(logic [PHYS_W-1:0] pa, logic [1:0] size,
                                   logic [1:0] status);
            walk_result_t want;
            if (pending_walks.size() == 0) begin
                $display("%0t: result with no lookup outstanding: %h %0d %0d",
                         $time, pa, size, status);
                errors++;
                return;
            end
            want = pending_walks.pop_front();
            if (pa !== want.phys) begin
                $display("%0t: phys_addr mismatch: expected %h, actual %h",
                         $time, want.phys, pa);
                errors++;
            end
            if (size !== want.size) begin
                $display("%0t: map_size mismatch: expected %0d, actual %0d",
                         $time, want.size, size);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return pending_walks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PA_W-1:0]      cfg_data;

    logic                 s_valid;
    logic                 s_ready;
    logic                 s_opcode;
    logic [63:0]          s_virtual_addr;
    logic [12:0]          s_word_index;
    logic [63:0]          s_descriptor;

    logic                 m_valid;
    logic                 m_ready;
    logic [PHYS_W-1:0]    m_phys_addr;
    logic [1:0]           m_map_size;
    logic [1:0]           m_status;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    translation_table_walker #(
        .WIN_PAGES (WIN_PAGES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_virtual_addr (s_virtual_addr),
        .s_word_index   (s_word_index),
        .s_descriptor   (s_descriptor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_phys_addr    (m_phys_addr),
        .m_map_size     (m_map_size),
        .m_status       (m_status)
    );

    translation_checker sb;

    // Pacing controls shared between the stimulus and the result sink.
    bit tx_no_gaps   = 1'b0;  // sender offers words back to back
    bit rx_no_stalls = 1'b0;  // receiver takes every result at once
    int hold_req     = 0;     // one long receiver hold-off, in cycles
    int words_sent   = 0;

    // A hung block ends the run here rather than hanging the simulator.
    int unsigned cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. It runs one decision per cycle: after each accepted result
    // it draws a fresh stall, and a hold-off request from the stimulus
    // overrides whatever stall is running.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_phys_addr, m_map_size, m_status);
                stall_left = rx_no_stalls ? 0 : $urandom_range(0, 11);
            end
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Page k of the window, counting from the first page boundary at or
    // above the window base.
    function automatic logic [63:0] page_at(logic [PA_W-1:0] base, int k);
        return (({16'b0, base} + PAGE_OFFSET) + 64'(k) * 64'h1000) & OA_MASK;
    endfunction

    // A root somewhere in the window. The low bits are junk on purpose, since
    // the block must ignore them.
    function automatic logic [PA_W-1:0] any_root(logic [PA_W-1:0] base);
        return PA_W'(page_at(base, $urandom_range(0, WIN_PAGES - 2))) |
               PA_W'(rand64() & PAGE_OFFSET);
    endfunction

    // Offers one input word and returns at the edge where it is taken. The
    // valid is left high so that a following word goes out without a bubble.
    task automatic send_word(input logic op, input logic [63:0] va,
                             input logic [12:0] slot, input logic [63:0] desc);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_virtual_addr <= va;
        s_word_index   <= slot;
        s_descriptor   <= desc;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(op, va, slot, desc);
        words_sent++;
    endtask

    task automatic store_desc(input logic [12:0] slot, input logic [63:0] desc);
        send_word(OP_WRITE, rand64(), slot, desc);
    endtask

    task automatic look_up(input logic [63:0] va);
        send_word(OP_LOOKUP, va, 13'($urandom()), rand64());
    endtask

    // Register write; cfg_valid stays high so that writes can follow back to
    // back, and the caller lowers it after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic program_walker(input logic [PA_W-1:0] base,
                                  input logic [PA_W-1:0] low_root,
                                  input logic [PA_W-1:0] high_root,
                                  input logic low_p, input logic high_p);
        cfg_write(CFG_WINDOW_BASE, base);
        cfg_write(CFG_LOW_ROOT, low_root);
        cfg_write(CFG_HIGH_ROOT, high_root);
        cfg_write(CFG_LOW_PRESENT, {{(PA_W-1){1'b0}}, low_p});
        cfg_write(CFG_HIGH_PRESENT, {{(PA_W-1){1'b0}}, high_p});
        cfg_valid <= 1'b0;
    endtask

    // Stops offering words, waits for every outstanding lookup to return, and
    // then gives a trailing descriptor write time to land.
    task automatic drain_walks();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (WALK_SETTLE) @(posedge aclk);
    endtask

    // Writes the descriptors along the walk of va, ending with a leaf of the
    // given type at level depth. Intermediate tables mostly land on window
    // pages, which may collide with other paths; now and then one points
    // anywhere in the address space, which usually leaves the window.
    task automatic lay_path(input logic [63:0] va, input int depth, input logic [1:0] leaf);
        logic [63:0] tbl;
        logic [63:0] next_tbl;
        logic [63:0] desc;
        logic [12:0] slot;
        int          lvl;
        tbl = {16'b0, (va[63] ? sb.high_root : sb.low_root)} & OA_MASK;
        for (lvl = 0; lvl <= depth; lvl++) begin
            if (!sb.entry_slot(tbl + (((va >> (39 - 9 * lvl)) & 64'h1FF) << 3), slot))
                break;
            if (lvl < depth) begin
                if ($urandom_range(0, 15) == 0)
                    next_tbl = rand64() & OA_MASK;
                else
                    next_tbl = page_at(sb.win_base, $urandom_range(0, WIN_PAGES - 2));
                desc = (rand64() & ~(OA_MASK | 64'h3)) | next_tbl | {62'b0, KIND_TABLE};
            end else begin
                next_tbl = '0;
                desc      = rand64();
                desc[1:0] = leaf;
            end
            store_desc(slot, desc);
            tbl = next_tbl;
        end
    endtask

    // Mostly well-formed walks with random content and a few lookups through
    // each, mixed with stray lookups and stray descriptor writes.
    task automatic random_traffic(input int count);
        int          stop_at;
        int          depth;
        int          reps;
        logic [63:0] va;
        logic [63:0] keep;
        logic [1:0]  leaf;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: look_up(rand64());
                1: store_desc(13'($urandom()), rand64());
                default: begin
                    va    = rand64();
                    depth = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
                    leaf  = (depth == 3) ? KIND_TABLE : KIND_BLOCK;
                    if ($urandom_range(0, 7) == 0)
                        leaf = 2'($urandom_range(0, 3));
                    lay_path(va, depth, leaf);
                    // Lookups vary the offset within the mapping and the
                    // unused upper bits, but keep the path to the leaf.
                    keep = 64'h8000_FFFF_FFFF_FFFF & ~((64'd1 << (39 - 9 * depth)) - 64'd1);
                    reps = $urandom_range(1, 3);
                    repeat (reps) look_up((va & keep) | (rand64() & ~keep));
                end
            endcase
        end
    endtask

    task automatic run_phase(input logic [PA_W-1:0] base, input logic low_p,
                             input logic high_p, input int count, input int hold);
        drain_walks();
        program_walker(base, any_root(base), any_root(base), low_p, high_p);
        if (hold != 0)
            hold_req = hold;
        random_traffic(count);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [PA_W-1:0] base;

        sb = new();
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_LOW_ROOT;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_WRITE;
        s_virtual_addr <= '0;
        s_word_index   <= '0;
        s_descriptor   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight out of reset both roots are absent, so both halves fault.
        // These words also sit through the clearing pass.
        look_up(64'h0000_0000_0000_0000);
        look_up(64'hFFFF_FFFF_FFFF_FFFF);
        drain_walks();

        // Window at address zero, low root on page 0, high root on page 1
        // with junk in the low twelve bits.
        cfg_write(CFG_SPARE, PA_W'(rand64()));
        program_walker('0, '0, 48'h0000_0000_1FFF, 1'b1, 1'b1);

        // The cleared memory holds only invalid descriptors.
        look_up(64'h0000_0000_0000_0000);

        // Level 0 entry 0 points at page 2. A 1 GB block there whose output
        // address plus the offset carries into bit 48.
        store_desc(13'd0, 64'hFFFF_0000_0000_2FFF);
        store_desc(13'd1024, 64'hFFFF_FFFF_FFFF_F001);
        look_up(64'h0000_0000_3FFF_FFFF);

        // Level 1 entry 1 points at page 3, which holds a 2 MB block.
        store_desc(13'd1025, 64'h0000_0000_0000_3003);
        store_desc(13'd1536, 64'h0000_8000_0020_0001);
        look_up(64'h0000_0000_401F_FFFF);

        // Level 2 entry 1 points at page 4; its last entry is a 4 KB page.
        store_desc(13'd1537, 64'h0000_0000_0000_4003);
        store_desc(13'd2559, 64'h7FFF_FFFF_FFFF_F003);
        look_up(64'h0000_0000_403F_FFFF);

        // A block descriptor at level 3 is not a page and faults.
        store_desc(13'd2558, 64'h0000_0000_0123_4001);
        look_up(64'h0000_0000_403F_E123);

        // A block descriptor at level 0 faults as well.
        store_desc(13'd1, 64'h0000_0000_4000_0001);
        look_up(64'h0000_0080_0000_0000);

        // High half: the root entry points at a table outside the window.
        store_desc(13'd512, 64'h0000_0000_0010_0003);
        look_up(64'h8000_0000_0000_0000);

        // Window at zero with no idling on either side at all.
        tx_no_gaps   = 1'b1;
        rx_no_stalls = 1'b1;
        run_phase('0, 1'b1, 1'b1, 70, 0);
        drain_walks();
        rx_no_stalls = 1'b0;

        // Window at the top of the address space. The receiver holds off for
        // a long stretch while the sender keeps offering words back to back,
        // so the block backs up and has to stall its input.
        run_phase(48'hFFFF_FFFE_0000, 1'b1, 1'b1, 80, 400);
        tx_no_gaps = 1'b0;

        // Window base at a random address, most likely off a word boundary.
        base = PA_W'(rand64());
        if (base >= 48'hFFFF_FFFE_0000)
            base = base - 48'h0002_0000;
        run_phase(base, 1'b1, 1'b1, 80, 0);

        // Low root absent: every low-half lookup faults.
        base = PA_W'(rand64()) & ~PA_W'(PAGE_OFFSET);
        if (base >= 48'hFFFF_FFFE_0000)
            base = base - 48'h0002_0000;
        run_phase(base, 1'b0, 1'b1, 60, 0);

        // All registers at their maximum; the roots fall below the window.
        drain_walks();
        program_walker('1, '1, '1, 1'b1, 1'b1);
        random_traffic(25);

        // A few more random settings, aligned or not.
        repeat (3) begin
            base = PA_W'(rand64());
            if ($urandom_range(0, 1) == 0)
                base = base & ~PA_W'(PAGE_OFFSET);
            if (base >= 48'hFFFF_FFFE_0000)
                base = base - 48'h0002_0000;
            run_phase(base, 1'($urandom_range(0, 7) != 0), 1'($urandom_range(0, 7) != 0),
                      70, 0);
        end

        drain_walks();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ttw_pkg.sv
hdl/ttw_ram.sv
hdl/ttw_datapath.sv
hdl/ttw_ctrl.sv
hdl/translation_table_walker.sv
tb/tb_translation_table_walker.sv
